/* hdl/asp_pkg.sv */
// Shared types and constants for the alarm safety supervisor.
package asp_pkg;

  localparam int unsigned CodeW      = 16;
  localparam int unsigned PumpW      = 4;
  localparam int unsigned PinchW     = 3;
  localparam int unsigned PumpCntW   = 7;
  localparam int unsigned PinchCntW  = 5;
  localparam int unsigned NumTemp    = 6;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 8;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [PumpCntW-1:0]  PumpCheckTicks  = 7'd65;
  localparam logic [PinchCntW-1:0] PinchCheckTicks = 5'd20;

  // one-hot pinch position codes
  localparam logic [PinchW-1:0] PinchClosed = 3'h1;
  localparam logic [PinchW-1:0] PinchLeft   = 3'h2;
  localparam logic [PinchW-1:0] PinchRight  = 3'h4;

  typedef enum logic [2:0] {
    RegNoError = 3'd0,
    RegTempA   = 3'd1,
    RegTempB   = 3'd2,
    RegTempC   = 3'd3,
    RegTempD   = 3'd4,
    RegTempE   = 3'd5,
    RegTempF   = 3'd6
  } reg_idx_e;

  // input beat, lowest field in the lowest bits
  typedef struct packed {
    logic [PinchW-1:0] venous_pinch_pos;
    logic [PinchW-1:0] arterial_pinch_pos;
    logic [PinchW-1:0] lower_pinch_pos;
    logic [PumpW-1:0]  pump_moving;
    logic [CodeW-1:0]  alarm_code;
  } tick_t;

  // result beat, lowest field in the lowest bits
  typedef struct packed {
    logic hunting;
    logic unrecoverable;
    logic enable_organ_checks;
    logic disable_organ_checks;
    logic hw_failure_alarm;
    logic switch_off_actuators;
    logic enable_actuators;
  } result_t;

endpackage

/* hdl/alarm_safety_supervisor.sv */
// Alarm safety supervisor: per-tick actuator supervision with APB configuration.
//
// One tick beat in, one result beat out. A tick is evaluated in the cycle it is
// accepted and its result lands in the output register on the same edge, so the
// block takes one tick per cycle while results are consumed. The output register
// frees itself in the cycle it is taken, so s_axis_tready_o stays high as long
// as the result is consumed. Codes, countdowns and the fatal latch are all held
// in flip-flops; configuration should be written only while no tick is in flight.
// After an unrecoverable failure the block keeps answering ticks with
// unrecoverable set and all pulses low, until reset.
module alarm_safety_supervisor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tick beats
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] alarm_code, [19:16] pump_moving, [22:20] lower_pinch_pos,
  // [25:23] arterial_pinch_pos, [28:26] venous_pinch_pos, [31:29] zero
  input  logic [asp_pkg::InDataW-1:0]    s_axis_tdata_i,
  // result beats
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] enable_actuators, [1] switch_off_actuators, [2] hw_failure_alarm,
  // [3] disable_organ_checks, [4] enable_organ_checks, [5] unrecoverable,
  // [6] hunting, [7] zero
  output logic [asp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // configuration
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [asp_pkg::ApbAddrW-1:0]   paddr_i,
  input  logic [asp_pkg::ApbDataW-1:0]   pwdata_i,
  output logic [asp_pkg::ApbDataW-1:0]   prdata_o,
  output logic                           pready_o
);

  // configuration registers
  logic [asp_pkg::CodeW-1:0] no_error_q;
  logic [asp_pkg::CodeW-1:0] temp_code_q [asp_pkg::NumTemp];

  // supervision state
  logic [asp_pkg::PumpCntW-1:0]  pump_cnt_q, pump_cnt_d;
  logic [asp_pkg::PinchCntW-1:0] pinch_cnt_q, pinch_cnt_d;
  logic                          hunting_q, hunting_d;
  logic                          fatal_q, fatal_d;
  logic [asp_pkg::CodeW-1:0]     prev_code_q, prev_code_d;

  // output register
  logic              out_valid_q;
  asp_pkg::result_t  res_q, res_d;

  asp_pkg::tick_t    tick;
  asp_pkg::reg_idx_e reg_idx;
  logic              in_fire;
  logic              cfg_wr;

  assign tick     = asp_pkg::tick_t'(s_axis_tdata_i[$bits(asp_pkg::tick_t)-1:0]);
  assign reg_idx  = asp_pkg::reg_idx_e'(paddr_i[asp_pkg::ApbAddrW-1:2]);
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q};

  // ---------------------------------------------------------------------------
  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_error_q <= '0;
      for (int k = 0; k < asp_pkg::NumTemp; k++) begin
        temp_code_q[k] <= '1;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        asp_pkg::RegNoError: no_error_q     <= pwdata_i[asp_pkg::CodeW-1:0];
        asp_pkg::RegTempA:   temp_code_q[0] <= pwdata_i[asp_pkg::CodeW-1:0];
        asp_pkg::RegTempB:   temp_code_q[1] <= pwdata_i[asp_pkg::CodeW-1:0];
        asp_pkg::RegTempC:   temp_code_q[2] <= pwdata_i[asp_pkg::CodeW-1:0];
        asp_pkg::RegTempD:   temp_code_q[3] <= pwdata_i[asp_pkg::CodeW-1:0];
        asp_pkg::RegTempE:   temp_code_q[4] <= pwdata_i[asp_pkg::CodeW-1:0];
        asp_pkg::RegTempF:   temp_code_q[5] <= pwdata_i[asp_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (reg_idx)
      asp_pkg::RegNoError: prdata_o[asp_pkg::CodeW-1:0] = no_error_q;
      asp_pkg::RegTempA:   prdata_o[asp_pkg::CodeW-1:0] = temp_code_q[0];
      asp_pkg::RegTempB:   prdata_o[asp_pkg::CodeW-1:0] = temp_code_q[1];
      asp_pkg::RegTempC:   prdata_o[asp_pkg::CodeW-1:0] = temp_code_q[2];
      asp_pkg::RegTempD:   prdata_o[asp_pkg::CodeW-1:0] = temp_code_q[3];
      asp_pkg::RegTempE:   prdata_o[asp_pkg::CodeW-1:0] = temp_code_q[4];
      asp_pkg::RegTempF:   prdata_o[asp_pkg::CodeW-1:0] = temp_code_q[5];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // tick evaluation
  logic                          code_is_temp, prev_is_temp;
  logic                          pinches_safe;
  logic                          changed, to_no_error;
  logic [asp_pkg::PumpCntW-1:0]  pump_ld;
  logic [asp_pkg::PinchCntW-1:0] pinch_ld;
  logic                          hunt_ld;
  logic                          pump_fail, pinch_fail, pinch_ok;

  always_comb begin
    code_is_temp = 1'b0;
    prev_is_temp = 1'b0;
    for (int k = 0; k < asp_pkg::NumTemp; k++) begin
      code_is_temp = code_is_temp || (temp_code_q[k] == tick.alarm_code);
      prev_is_temp = prev_is_temp || (temp_code_q[k] == prev_code_q);
    end
  end

  assign pinches_safe =
      (tick.lower_pinch_pos == asp_pkg::PinchClosed ||
       tick.lower_pinch_pos == asp_pkg::PinchLeft) &&
      (tick.arterial_pinch_pos == asp_pkg::PinchClosed ||
       tick.arterial_pinch_pos == asp_pkg::PinchRight) &&
      (tick.venous_pinch_pos == asp_pkg::PinchClosed ||
       tick.venous_pinch_pos == asp_pkg::PinchRight);

  assign changed     = tick.alarm_code != prev_code_q;
  assign to_no_error = changed && (tick.alarm_code == no_error_q);

  always_comb begin
    // code change: clear on no-error, then load on temperature alarm
    pump_ld  = to_no_error ? '0 : pump_cnt_q;
    pinch_ld = to_no_error ? '0 : pinch_cnt_q;
    hunt_ld  = to_no_error || hunting_q;
    if (changed && code_is_temp) begin
      pump_ld  = asp_pkg::PumpCheckTicks;
      pinch_ld = asp_pkg::PinchCheckTicks;
    end

    pump_cnt_d  = (pump_ld != '0) ? pump_ld - 1'b1 : pump_ld;
    pinch_cnt_d = (pinch_ld != '0) ? pinch_ld - 1'b1 : pinch_ld;

    // a check fires on the tick its countdown reaches zero
    pump_fail  = (pump_ld == asp_pkg::PumpCntW'(1)) && (tick.pump_moving != '0);
    pinch_fail = (pinch_ld == asp_pkg::PinchCntW'(1)) && !pinches_safe;
    pinch_ok   = (pinch_ld == asp_pkg::PinchCntW'(1)) && pinches_safe;

    hunting_d   = hunt_ld && pinches_safe;
    fatal_d     = pump_fail || pinch_fail;
    prev_code_d = tick.alarm_code;

    res_d.enable_actuators     = to_no_error && !prev_is_temp;
    res_d.switch_off_actuators = fatal_d;
    res_d.hw_failure_alarm     = fatal_d;
    res_d.disable_organ_checks = pinch_ok;
    res_d.enable_organ_checks  = hunt_ld && !pinches_safe;
    res_d.unrecoverable        = fatal_d;
    res_d.hunting              = hunting_d;

    if (fatal_q) begin
      res_d               = '0;
      res_d.unrecoverable = 1'b1;
      res_d.hunting       = hunting_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_cnt_q  <= '0;
      pinch_cnt_q <= '0;
      hunting_q   <= 1'b0;
      fatal_q     <= 1'b0;
      prev_code_q <= '0;
    end else if (in_fire && !fatal_q) begin
      pump_cnt_q  <= pump_cnt_d;
      pinch_cnt_q <= pinch_cnt_d;
      hunting_q   <= hunting_d;
      fatal_q     <= fatal_d;
      prev_code_q <= prev_code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  a_fatal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fatal_q |=> fatal_q)
    else $error("fatal latch cleared without reset");

  a_latched_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && fatal_q) |=> (out_valid_q && res_q.unrecoverable &&
      !res_q.enable_actuators && !res_q.switch_off_actuators &&
      !res_q.hw_failure_alarm && !res_q.disable_organ_checks &&
      !res_q.enable_organ_checks))
    else $error("latched tick produced a pulse");

  a_failure_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.switch_off_actuators == res_q.hw_failure_alarm))
    else $error("switch-off and hw-failure pulses differ");

  a_hunt_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.enable_organ_checks) |-> !res_q.hunting)
    else $error("organ checks enabled while still hunting");

  a_ready_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (out_valid_q && !m_axis_tready_i))
    else $error("input stalled without output backpressure");

endmodule
